@@ rtl/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// pts_pkg
// shared types and constants of the periodic task scheduler (rm / edf)
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int MAX_TASKS  = 16;
	localparam int TIME_WIDTH = 32;
	localparam int IDX_W      = $clog2(MAX_TASKS);
	localparam int CNT_W      = $clog2(MAX_TASKS + 1);
	localparam int WORK_W     = 16;
	localparam int ADDR_W     = 3;

	localparam logic [1:0] KIND_TICK    = 2'd0;
	localparam logic [1:0] KIND_WRITE   = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	localparam logic [0:0] REG_MODE  = 1'b0;
	localparam logic [0:0] REG_COUNT = 1'b1;

	typedef struct packed {
		logic [1:0]        kind;
		logic [3:0]        task_index;
		logic [WORK_W-1:0] burst_time;
		logic [WORK_W-1:0] period;
		logic [WORK_W-1:0] rel_deadline;
	} req_t;

	typedef struct packed {
		logic        run_valid;
		logic [3:0]  run_task;
		logic [31:0] tick_time;
	} res_t;

	typedef struct packed {
		logic [WORK_W-1:0] burst;
		logic [WORK_W-1:0] period;
		logic [WORK_W-1:0] rel_deadline;
	} task_cfg_t;

	typedef struct packed {
		logic [WORK_W-1:0]     remaining;
		logic [TIME_WIDTH-1:0] next_release;
		logic [TIME_WIDTH-1:0] abs_deadline;
	} task_run_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

endpackage

@@ rtl/periodic_task_scheduler_rm_edf.sv @@
// ----------------------------------------------------------------------------
// periodic_task_scheduler_rm_edf
// tick-driven scheduler for periodic tasks, rate monotonic or earliest deadline
// first, with the task table held in two synchronous memories
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// req       in         req_valid/req_ready  req_t (kind, task_index, burst_time,
//                                           period, rel_deadline)
// res       out        res_valid/res_ready  res_t (run_valid, run_task, tick_time)
// apb       in/out     psel/penable/pready  mode at 0x0, task_count at 0x4
//
// a tick request keeps req_ready low until the tick is done; the scan covers
// task_count entries, saturated at 16: one entry of the run-state memory is
// read per cycle and evaluated and written back in the next cycle; once no
// read is pending the scan closes, then the chosen task is written once more
// and the result stored; write and restart requests leave req_ready high
// reset clears time, mode and the per-entry valid bits and sets task_count to 1,
// so the run state reads as zero without a clearing pass
// a finished tick waits in the final state while the result register is still
// full; new requests are taken while a result waits
// ----------------------------------------------------------------------------
module periodic_task_scheduler_rm_edf import pts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_t              req,
	output logic              res_valid,
	input  logic              res_ready,
	output res_t              res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	state_t state_q, state_d;

	logic                  mode_q;
	logic [4:0]            task_count_q;
	logic [TIME_WIDTH-1:0] now_q;

	task_cfg_t cfg_mem [MAX_TASKS];
	task_run_t run_mem [MAX_TASKS];
	logic [MAX_TASKS-1:0] vld_q;

	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_sat;
	logic             rd_en;
	logic             rd_s1;
	logic [IDX_W-1:0] addr_s1;
	task_cfg_t        cfg_s1;
	task_run_t        run_raw_s1;
	logic             vld_s1;

	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [TIME_WIDTH-1:0] best_key_q;
	task_run_t             best_row_q;

	task_run_t             row_in;
	task_run_t             row_new;
	logic                  release_hit;
	logic [TIME_WIDTH-1:0] key;
	logic                  cand;

	logic                  fin_go;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	task_run_t             wr_data;

	logic req_acc, cfg_wr;

	res_t res_q;
	logic res_valid_q;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign req_acc = req_valid && req_ready;

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_MODE:  prdata = {31'b0, mode_q};
			REG_COUNT: prdata = {27'b0, task_count_q};
			default:   prdata = '0;
		endcase
	end

	assign cnt_sat = (task_count_q > 5'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
	                                                : CNT_W'(task_count_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rd_en     = 1'b0;
		fin_go    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid && req.kind == KIND_TICK) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = (idx_q < cnt_sat);
				if (!rd_en && !rd_s1) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				fin_go = !res_valid_q || res_ready;
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// evaluation of the entry read in the previous cycle
	always_comb begin
		row_in      = vld_s1 ? run_raw_s1 : '0;
		release_hit = (row_in.next_release == now_q);
		row_new     = row_in;
		if (release_hit) begin
			row_new.remaining    = cfg_s1.burst;
			row_new.next_release = row_in.next_release + TIME_WIDTH'(cfg_s1.period);
			row_new.abs_deadline = now_q + TIME_WIDTH'(mode_q ? cfg_s1.rel_deadline
			                                                  : cfg_s1.period);
		end
		key  = mode_q ? row_new.abs_deadline : TIME_WIDTH'(cfg_s1.period);
		cand = (row_new.remaining != '0) && (!found_q || key < best_key_q);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = row_new;
		if (state_q == ST_SCAN && rd_s1) begin
			wr_en = 1'b1;
		end else if (state_q == ST_FIN && fin_go && found_q) begin
			wr_en             = 1'b1;
			wr_addr           = best_idx_q;
			wr_data           = best_row_q;
			wr_data.remaining = best_row_q.remaining - WORK_W'(1);
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (req_acc && req.kind == KIND_WRITE) begin
			cfg_mem[req.task_index] <= '{req.burst_time, req.period, req.rel_deadline};
		end
		if (wr_en) begin
			run_mem[wr_addr] <= wr_data;
		end
		cfg_s1     <= cfg_mem[idx_q[IDX_W-1:0]];
		run_raw_s1 <= run_mem[idx_q[IDX_W-1:0]];
		vld_s1     <= vld_q[idx_q[IDX_W-1:0]];
		addr_s1    <= idx_q[IDX_W-1:0];
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			task_count_q <= 5'd1;
			now_q        <= '0;
			vld_q        <= '0;
			idx_q        <= '0;
			rd_s1        <= 1'b0;
			found_q      <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[2])
					REG_MODE:  mode_q       <= pwdata[0];
					REG_COUNT: task_count_q <= pwdata[4:0];
					default:   mode_q       <= mode_q;
				endcase
			end
			rd_s1 <= rd_en;
			if (rd_en) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (req_acc) begin
				unique case (req.kind)
					KIND_TICK: begin
						idx_q   <= '0;
						found_q <= 1'b0;
					end
					KIND_WRITE:   vld_q[req.task_index] <= 1'b0;
					KIND_RESTART: begin
						vld_q <= '0;
						now_q <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == ST_SCAN && rd_s1 && cand) begin
				found_q <= 1'b1;
			end
			if (fin_go) begin
				res_valid_q <= 1'b1;
				now_q       <= now_q + TIME_WIDTH'(1);
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// best candidate and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && rd_s1 && cand) begin
			best_idx_q <= addr_s1;
			best_key_q <= key;
			best_row_q <= row_new;
		end
		if (fin_go) begin
			res_q.run_valid <= found_q;
			res_q.run_task  <= found_q ? 4'(best_idx_q) : 4'd0;
			res_q.tick_time <= 32'(now_q);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ rtl/pts_checker.sv @@
// ----------------------------------------------------------------------------
// pts_checker
// port-level checks of the periodic task scheduler, bound to the top level
// ----------------------------------------------------------------------------
module pts_checker import pts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic res_valid,
	input logic res_ready,
	input res_t res,
	input logic pready
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result dropped or changed while stalled");

	a_idle_task: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.run_valid |-> res.run_task == 4'd0)
		else $error("idle result carries a task index");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.kind == KIND_TICK |=> !req_ready)
		else $error("request taken while a tick is scanned");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind periodic_task_scheduler_rm_edf pts_checker u_pts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res),
	.pready    (pready)
);
